@@ hdl/ntw_pkg.sv @@
// Package for the number-to-word-tokens unit: widths, word keys, the token
// struct, group codes and the back-end phase enum. No dependencies.
`default_nettype none
package ntw_pkg;

  localparam int unsigned ValueW   = 32;
  localparam int unsigned KeyW     = 30;
  localparam int unsigned NumDig   = 10;
  localparam int unsigned BcdW     = 4 * NumDig;
  localparam int unsigned IterW    = $clog2(ValueW);

  localparam logic [IterW-1:0] IterLast = IterW'(ValueW - 1);

  localparam logic [KeyW-1:0] KeyHundred  = KeyW'(100);
  localparam logic [KeyW-1:0] KeyThousand = KeyW'(1000);
  localparam logic [KeyW-1:0] KeyMillion  = KeyW'(1000000);
  localparam logic [KeyW-1:0] KeyBillion  = KeyW'(1000000000);
  localparam logic [KeyW-1:0] KeyZero     = '0;

  // digit groups, walked from billions down to units
  localparam logic [1:0] GrpBil = 2'd3;
  localparam logic [1:0] GrpMil = 2'd2;
  localparam logic [1:0] GrpTho = 2'd1;
  localparam logic [1:0] GrpUni = 2'd0;

  typedef logic [BcdW-1:0] bcd_t;

  typedef struct packed {
    logic [KeyW-1:0] word_key;
    logic            space_after;
    logic            last;
  } token_t;

  typedef enum logic [2:0] {
    PH_HDIG,
    PH_HWORD,
    PH_TENS,
    PH_UNIT,
    PH_SCALE,
    PH_DONE
  } ntw_phase_e;

endpackage
`default_nettype wire

@@ hdl/ntw_front.sv @@
// Front end: one-item input holding register and a bit-serial binary to
// BCD converter (shift and add-3). Depends on ntw_pkg.
`default_nettype none
module ntw_front (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           push,
  output logic                           full,
  input  logic [ntw_pkg::ValueW-1:0]     value_i,
  output logic                           dq_push_o,
  output ntw_pkg::bcd_t                  dq_data_o,
  input  logic                           dq_full_i
);
  import ntw_pkg::*;

  logic [ValueW-1:0] hold_q, hold_d;
  logic              hold_vld_q, hold_vld_d;
  logic              busy_q, busy_d;
  logic [IterW-1:0]  cnt_q, cnt_d;
  logic [ValueW-1:0] shift_q, shift_d;
  bcd_t              bcd_q, bcd_d;
  bcd_t              bcd_adj;
  bcd_t              bcd_nxt;
  logic              step, finish, load;

  assign full = hold_vld_q;

  // add 3 to every digit of 5 or more before the shift
  always_comb begin
    bcd_adj = bcd_q;
    for (int i = 0; i < NumDig; i++) begin
      if (bcd_q[4*i +: 4] >= 4'd5) begin
        bcd_adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
      end
    end
  end

  assign bcd_nxt = {bcd_adj[BcdW-2:0], shift_q[ValueW-1]};

  assign step   = busy_q && ((cnt_q != IterLast) || !dq_full_i);
  assign finish = step && (cnt_q == IterLast);
  assign load   = hold_vld_q && (!busy_q || finish);

  assign dq_push_o = finish;
  assign dq_data_o = bcd_nxt;

  always_comb begin
    hold_d     = hold_q;
    hold_vld_d = hold_vld_q;
    busy_d     = busy_q;
    cnt_d      = cnt_q;
    shift_d    = shift_q;
    bcd_d      = bcd_q;
    if (step) begin
      shift_d = {shift_q[ValueW-2:0], 1'b0};
      bcd_d   = bcd_nxt;
      cnt_d   = cnt_q + IterW'(1);
    end
    if (finish) begin
      busy_d = 1'b0;
      cnt_d  = '0;
    end
    if (load) begin
      busy_d     = 1'b1;
      cnt_d      = '0;
      shift_d    = hold_q;
      bcd_d      = '0;
      hold_vld_d = 1'b0;
    end
    if (push && !full) begin
      hold_d     = value_i;
      hold_vld_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_vld_q <= 1'b0;
      busy_q     <= 1'b0;
      cnt_q      <= '0;
    end else begin
      hold_vld_q <= hold_vld_d;
      busy_q     <= busy_d;
      cnt_q      <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hold_q  <= hold_d;
    shift_q <= shift_d;
    bcd_q   <= bcd_d;
  end

  a_push_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dq_push_o |-> busy_q && (cnt_q == IterLast))
    else $error("digit push outside last iteration");

  a_idle_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_q |-> (cnt_q == '0))
    else $error("iteration count not cleared while idle");

  a_start_from_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && (cnt_q == '0)) |-> $past(hold_vld_q))
    else $error("conversion started without held item");

endmodule
`default_nettype wire

@@ hdl/ntw_digit_q.sv @@
// Two-entry queue of BCD digit sets between front and back end.
// Depends on ntw_pkg.
`default_nettype none
module ntw_digit_q (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  ntw_pkg::bcd_t data_i,
  output logic          full_o,
  input  logic          pop_i,
  output ntw_pkg::bcd_t data_o,
  output logic          empty_o
);
  import ntw_pkg::*;

  bcd_t       mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q, cnt_d;
  logic       do_push, do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign data_o  = mem_q[rp_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    cnt_d = cnt_q;
    case ({do_push, do_pop})
      2'b10:   cnt_d = cnt_q + 2'd1;
      2'b01:   cnt_d = cnt_q - 2'd1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
      if (do_push) wp_q <= ~wp_q;
      if (do_pop)  rp_q <= ~rp_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wp_q] <= data_i;
  end

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3)
    else $error("digit queue count out of range");

  a_ptr_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((cnt_q == 2'd0) || (cnt_q == 2'd2)) |-> (wp_q == rp_q))
    else $error("digit queue pointers disagree with count");

  a_no_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && full_o) |-> !$past(push_i && full_o && !pop_i) || full_o)
    else $error("digit queue overflow handling");

endmodule
`default_nettype wire

@@ hdl/ntw_back.sv @@
// Back end: walks the digit groups, emits word tokens through a one-token
// hold stage (for the last flag) into a two-entry result queue. Uses ntw_pkg.
`default_nettype none
module ntw_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  ntw_pkg::bcd_t               dq_data_i,
  input  logic                        dq_empty_i,
  output logic                        dq_pop_o,
  output logic                        empty,
  input  logic                        pop,
  output logic [ntw_pkg::KeyW-1:0]    word_key_o,
  output logic                        space_after_o,
  output logic                        last_o
);
  import ntw_pkg::*;

  ntw_phase_e phase_q, phase_d;
  logic [1:0] grp_q, grp_d;

  token_t     pend_q, pend_d;
  logic       pend_vld_q, pend_vld_d;

  token_t     omem_q [2];
  logic       owp_q, orp_q;
  logic [1:0] ocnt_q, ocnt_d;
  logic       ofull, opush, opop;
  token_t     opush_tok;

  logic [3:0] dh, dt, du;
  logic       grp_nz, tail_sep;
  logic       emit, adv;
  token_t     tok;
  logic [KeyW-1:0] scale_key;

  // digits of the current group
  always_comb begin
    dh = 4'd0;
    dt = 4'd0;
    du = 4'd0;
    scale_key = KeyThousand;
    case (grp_q)
      GrpBil: begin
        du = dq_data_i[39:36];
        scale_key = KeyBillion;
      end
      GrpMil: begin
        dh = dq_data_i[35:32];
        dt = dq_data_i[31:28];
        du = dq_data_i[27:24];
        scale_key = KeyMillion;
      end
      GrpTho: begin
        dh = dq_data_i[23:20];
        dt = dq_data_i[19:16];
        du = dq_data_i[15:12];
        scale_key = KeyThousand;
      end
      default: begin
        dh = dq_data_i[11:8];
        dt = dq_data_i[7:4];
        du = dq_data_i[3:0];
      end
    endcase
  end

  assign grp_nz   = (dh != 4'd0) || (dt != 4'd0) || (du != 4'd0);
  assign tail_sep = (grp_q != GrpUni);
  assign ofull    = (ocnt_q == 2'd2);

  // token of the current step and stall decision
  always_comb begin
    emit = 1'b0;
    tok  = '{word_key: KeyZero, space_after: 1'b1, last: 1'b0};
    case (phase_q)
      PH_HDIG: begin
        emit         = (dh != 4'd0);
        tok.word_key = KeyW'(dh);
      end
      PH_HWORD: begin
        emit         = (dh != 4'd0);
        tok.word_key = KeyHundred;
      end
      PH_TENS: begin
        emit = (dt != 4'd0);
        if (dt == 4'd1) begin
          tok.word_key    = KeyW'(5'd10 + {1'b0, du});
          tok.space_after = tail_sep;
        end else begin
          tok.word_key = KeyW'({dt, 3'b000} + {2'b00, dt, 1'b0});
        end
      end
      PH_UNIT: begin
        emit            = (dt != 4'd1) && (du != 4'd0);
        tok.word_key    = KeyW'(du);
        tok.space_after = tail_sep;
      end
      PH_SCALE: begin
        emit         = grp_nz && (grp_q != GrpUni);
        tok.word_key = scale_key;
      end
      default: begin
        emit = 1'b0;
      end
    endcase
    if (dq_empty_i) begin
      adv = 1'b0;
    end else if (phase_q == PH_DONE) begin
      adv = !ofull;
    end else begin
      adv = !(emit && pend_vld_q && ofull);
    end
  end

  // next phase and group
  always_comb begin
    phase_d = phase_q;
    grp_d   = grp_q;
    if (adv) begin
      case (phase_q)
        PH_HDIG:  phase_d = PH_HWORD;
        PH_HWORD: phase_d = PH_TENS;
        PH_TENS:  phase_d = PH_UNIT;
        PH_UNIT:  phase_d = (grp_q == GrpUni) ? PH_DONE : PH_SCALE;
        PH_SCALE: begin
          phase_d = PH_HDIG;
          grp_d   = grp_q - 2'd1;
        end
        default: begin
          phase_d = PH_HDIG;
          grp_d   = GrpBil;
        end
      endcase
    end
  end

  // hold stage and result queue push
  always_comb begin
    pend_d     = pend_q;
    pend_vld_d = pend_vld_q;
    opush      = 1'b0;
    opush_tok  = pend_q;
    if (adv) begin
      if (phase_q == PH_DONE) begin
        opush      = 1'b1;
        pend_vld_d = 1'b0;
        if (pend_vld_q) begin
          opush_tok.last = 1'b1;
        end else begin
          opush_tok = '{word_key: KeyZero, space_after: 1'b0, last: 1'b1};
        end
      end else if (emit) begin
        opush      = pend_vld_q;
        opush_tok  = pend_q;
        pend_d     = tok;
        pend_vld_d = 1'b1;
      end
    end
  end

  assign dq_pop_o = adv && (phase_q == PH_DONE);

  // result queue
  assign empty         = (ocnt_q == 2'd0);
  assign opop          = pop && !empty;
  assign word_key_o    = omem_q[orp_q].word_key;
  assign space_after_o = omem_q[orp_q].space_after;
  assign last_o        = omem_q[orp_q].last;

  always_comb begin
    case ({opush, opop})
      2'b10:   ocnt_d = ocnt_q + 2'd1;
      2'b01:   ocnt_d = ocnt_q - 2'd1;
      default: ocnt_d = ocnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_HDIG;
      grp_q      <= GrpBil;
      pend_vld_q <= 1'b0;
      owp_q      <= 1'b0;
      orp_q      <= 1'b0;
      ocnt_q     <= 2'd0;
    end else begin
      phase_q    <= phase_d;
      grp_q      <= grp_d;
      pend_vld_q <= pend_vld_d;
      ocnt_q     <= ocnt_d;
      if (opush) owp_q <= ~owp_q;
      if (opop)  orp_q <= ~orp_q;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_q <= pend_d;
    if (opush) omem_q[owp_q] <= opush_tok;
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    opush |-> !ofull)
    else $error("result queue written while full");

  a_pop_at_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dq_pop_o |-> (phase_q == PH_DONE) && !dq_empty_i)
    else $error("digit set released before its tokens");

  a_clean_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((phase_q == PH_HDIG) && (grp_q == GrpBil)) |-> !pend_vld_q)
    else $error("token of previous item left in hold stage");

  a_last_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (opush && opush_tok.last) |-> (phase_q == PH_DONE))
    else $error("last flag outside end of item");

endmodule
`default_nettype wire

@@ hdl/number_to_word_tokens_unit.sv @@
// Top level of the number-to-word-tokens unit: front end, digit queue and
// back end. Depends on ntw_pkg, ntw_front, ntw_digit_q and ntw_back.
//
//   channel  | handshake            | payload
//   ---------+----------------------+----------------------------------------
//   input    | push / full          | value_i[31:0]
//   results  | empty / pop          | word_key_o[29:0], space_after_o, last_o
//
// Flow: the front converts a value one bit per cycle in the shift-and-add-3
// converter, stalling on the last bit while the digit queue is full; a
// second item waits in the input holding register while one converts.
// The back walks its digit groups one step per cycle, then closes the item;
// it stalls on an empty digit queue or on a full result queue it must push to.
// Reset: rst_ni clears all control state at once; no clearing pass.
// Stalls: a full result queue stalls only the back; the two-entry digit
// queue lets the front keep converting until it too fills.
`default_nettype none
module number_to_word_tokens_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push,
  output logic                        full,
  input  logic [ntw_pkg::ValueW-1:0]  value_i,
  output logic                        empty,
  input  logic                        pop,
  output logic [ntw_pkg::KeyW-1:0]    word_key_o,
  output logic                        space_after_o,
  output logic                        last_o
);
  import ntw_pkg::*;

  // front -> digit queue
  logic dq_push;
  bcd_t dq_wdata;
  logic dq_full;

  // digit queue -> back
  bcd_t dq_rdata;
  logic dq_empty;
  logic dq_pop;

  // value in, BCD digit set out after 32 shift steps
  ntw_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push      (push),
    .full      (full),
    .value_i   (value_i),
    .dq_push_o (dq_push),
    .dq_data_o (dq_wdata),
    .dq_full_i (dq_full)
  );

  // decouples conversion from token emission
  ntw_digit_q u_digit_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (dq_push),
    .data_i  (dq_wdata),
    .full_o  (dq_full),
    .pop_i   (dq_pop),
    .data_o  (dq_rdata),
    .empty_o (dq_empty)
  );

  // group walk; each token waits in a one-token hold stage so the last flag of
  // an item is known when its last token enters the result queue
  ntw_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .dq_data_i     (dq_rdata),
    .dq_empty_i    (dq_empty),
    .dq_pop_o      (dq_pop),
    .empty         (empty),
    .pop           (pop),
    .word_key_o    (word_key_o),
    .space_after_o (space_after_o),
    .last_o        (last_o)
  );

endmodule
`default_nettype wire

@@ verif/number_to_word_tokens_unit_tb.sv @@
// Testbench for number_to_word_tokens_unit: drives 32-bit values through the
// push/full side and checks every word token popped against a spelling model.
// Depends on ntw_pkg and the RTL of number_to_word_tokens_unit.
`default_nettype none

// Spells each accepted value into the word tokens it must produce and checks
// popped tokens against them in order.
class spoken_word_checker;

  ntw_pkg::token_t expected_tokens[$];
  int unsigned     values_seen;
  int unsigned     tokens_checked;
  int unsigned     mismatches;
  int unsigned     longest_sentence;

  function void add_word(input int unsigned key, input logic sep);
    ntw_pkg::token_t word;
    word.word_key    = key[ntw_pkg::KeyW-1:0];
    word.space_after = sep;
    word.last        = 1'b0;
    expected_tokens.push_back(word);
  endfunction

  // up to three digits; closing_sep goes on the group's unit or 10-19 word, hundred and tens words take a space
  function void spell_group(input int unsigned grp, input logic closing_sep);
    int unsigned pair;
    int unsigned unit;
    pair = grp % 100;
    unit = grp % 10;
    if (grp > 99) begin
      add_word(grp / 100, 1'b1);
      add_word(ntw_pkg::KeyHundred, 1'b1);
    end
    if (pair > 19) begin
      add_word((pair / 10) * 10, 1'b1);
      if (unit != 0) add_word(unit, closing_sep);
    end else if (pair != 0) begin
      add_word(pair, closing_sep);
    end
  endfunction

  function void note_value(input logic [ntw_pkg::ValueW-1:0] value);
    int unsigned v;
    int unsigned billions;
    int unsigned millions;
    int unsigned thousands;
    int unsigned units;
    int unsigned start_size;
    ntw_pkg::token_t closing;
    v          = value;
    billions   = v / ntw_pkg::KeyBillion;
    millions   = (v % ntw_pkg::KeyBillion) / ntw_pkg::KeyMillion;
    thousands  = (v % ntw_pkg::KeyMillion) / ntw_pkg::KeyThousand;
    units      = v % ntw_pkg::KeyThousand;
    start_size = expected_tokens.size();
    values_seen++;
    if (v == 0) add_word(ntw_pkg::KeyZero, 1'b0);
    if (billions != 0) begin
      spell_group(billions, 1'b1);
      add_word(ntw_pkg::KeyBillion, 1'b1);
    end
    if (millions != 0) begin
      spell_group(millions, 1'b1);
      add_word(ntw_pkg::KeyMillion, 1'b1);
    end
    if (thousands != 0) begin
      spell_group(thousands, 1'b1);
      add_word(ntw_pkg::KeyThousand, 1'b1);
    end
    spell_group(units, 1'b0);
    closing      = expected_tokens.pop_back();
    closing.last = 1'b1;
    expected_tokens.push_back(closing);
    if (expected_tokens.size() - start_size > longest_sentence)
      longest_sentence = expected_tokens.size() - start_size;
  endfunction

  function void check_token(input logic [ntw_pkg::KeyW-1:0] key, input logic sep,
                            input logic fin);
    ntw_pkg::token_t want;
    if (expected_tokens.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected token: key %0d space_after %0b last %0b", key, sep, fin);
      return;
    end
    want = expected_tokens.pop_front();
    tokens_checked++;
    if (want.word_key !== key || want.space_after !== sep || want.last !== fin) begin
      mismatches++;
      if (mismatches <= 10)
        $display({"token %0d mismatch: expected key %0d sep %0b last %0b,",
                  " got key %0d sep %0b last %0b"},
                 tokens_checked, want.word_key, want.space_after, want.last, key, sep, fin);
    end
  endfunction

  function int unsigned pending();
    return expected_tokens.size();
  endfunction

endclass

module number_to_word_tokens_unit_tb;

  localparam int unsigned CycleLimit     = 500000;
  localparam int unsigned LongHoldCycles = 1500;
  // covers the front and the back of the last item, with margin
  localparam int unsigned TailCycles     = 120;

  logic                        clk_i   = 1'b0;
  logic                        rst_ni  = 1'b0;
  logic                        push    = 1'b0;
  logic                        full;
  logic [ntw_pkg::ValueW-1:0]  value_i = '0;
  logic                        empty;
  logic                        pop     = 1'b0;
  logic [ntw_pkg::KeyW-1:0]    word_key_o;
  logic                        space_after_o;
  logic                        last_o;

  spoken_word_checker spoken_words = new();

  // idle bursts on both sides while set; cleared for the last stretch
  bit          idle_on       = 1'b1;
  // asks the receiver for one long hold-off
  bit          long_hold_req = 1'b0;
  int unsigned full_stalls   = 0;

  number_to_word_tokens_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .value_i       (value_i),
    .empty         (empty),
    .pop           (pop),
    .word_key_o    (word_key_o),
    .space_after_o (space_after_o),
    .last_o        (last_o)
  );

  always #6 clk_i = ~clk_i;

  // Handshake monitor. Inputs change only by NBA at the edge, so values read
  // here are the ones the block saw at this edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (push && !full) spoken_words.note_value(value_i);
      if (push && full) full_stalls++;
      if (pop && !empty) spoken_words.check_token(word_key_o, space_after_o, last_o);
    end
  end

  // Offer one value; an optional idle burst goes first. Returns at the
  // edge that accepted it, with push still high.
  task automatic offer_value(input logic [ntw_pkg::ValueW-1:0] v);
    if (idle_on && $urandom_range(0, 9) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk_i);
    end
    push    <= 1'b1;
    value_i <= v;
    do @(posedge clk_i); while (full);
  endtask

  // Sender stops and waits until every expected token has been popped.
  task automatic drain_results();
    push <= 1'b0;
    do @(posedge clk_i); while (spoken_words.pending() != 0);
  endtask

  // One spoken group of 0..999, biased toward the interesting shapes.
  function automatic int unsigned pick_group();
    case ($urandom_range(0, 5))
      0:       return 0;
      1:       return $urandom_range(1, 19);
      2:       return $urandom_range(2, 9) * 10;
      3:       return $urandom_range(1, 9) * 100;
      default: return $urandom_range(0, 999);
    endcase
  endfunction

  function automatic logic [ntw_pkg::ValueW-1:0] random_value();
    longint unsigned v;
    case ($urandom_range(0, 9))
      0, 1: return $urandom;
      2:    return $urandom_range(0, 999);
      default: begin
        v = longint'($urandom_range(0, 4)) * 1000000000 + longint'(pick_group()) * 1000000
          + longint'(pick_group()) * 1000 + longint'(pick_group());
        // four billion plus a large rest overflows 32 bits: drop a billion
        if (v > 64'hFFFF_FFFF) v = v - 1000000000;
        return v[ntw_pkg::ValueW-1:0];
      end
    endcase
  endfunction

  // Receiver: pop stays high except during idle bursts and the long hold.
  initial begin : receiver
    int unsigned hold_left;
    hold_left = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold_left     = LongHoldCycles;
      end else if (hold_left == 0 && idle_on && $urandom_range(0, 11) == 0) begin
        hold_left = $urandom_range(1, 17);
      end
      if (hold_left != 0) begin
        pop <= 1'b0;
        hold_left--;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("number_to_word_tokens_unit_tb: FAIL");
    $finish;
  end

  initial begin : stimulus
    logic [ntw_pkg::ValueW-1:0] directed[$];
    bit failed;
    // zero, the 10-19 words, round tens and hundreds, every scale word,
    // zero groups between scales, the largest billions digit and all ones
    directed = '{0, 1, 9, 10, 11, 19, 20, 21, 90, 99, 100, 110, 115, 999, 1000, 1010,
                 1000000, 1000000000, 1000000001, 32'd4000000000, 32'hFFFF_FFFF,
                 123456789, 700000300, 32'h8000_0000, 32'd3000011019};

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed[i]) offer_value(directed[i]);

    // sender pause until everything is out
    drain_results();

    // receiver holds off while the sender keeps offering: queues fill and
    // full must back-pressure the input
    long_hold_req = 1'b1;
    repeat (60) offer_value(random_value());

    repeat (170) offer_value(random_value());
    drain_results();

    // back-to-back stretch, no idling on either side
    idle_on = 1'b0;
    repeat (55) offer_value(random_value());
    push <= 1'b0;

    while (spoken_words.pending() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);

    failed = spoken_words.mismatches != 0 || spoken_words.pending() != 0;
    if (spoken_words.pending() != 0)
      $display("%0d expected tokens never arrived", spoken_words.pending());
    $display("spelled %0d values into %0d tokens (longest %0d), %0d mismatches",
             spoken_words.values_seen, spoken_words.tokens_checked,
             spoken_words.longest_sentence, spoken_words.mismatches);
    $display("input back-pressure seen on %0d edges", full_stalls);
    if (!failed) begin
      $display("number_to_word_tokens_unit_tb: PASS");
    end else begin
      $display("number_to_word_tokens_unit_tb: FAIL");
    end
    $finish;
  end

endmodule
`default_nettype wire
